### rtl/hpd_pkg.sv
package hpd_pkg;

  // Angle scaling: headings are integers in units of 2^-ANGLE_FRAC_BITS degree.
  localparam int ANGLE_FRAC_BITS = 4;
  localparam int UNIT            = 1 << ANGLE_FRAC_BITS;
  localparam int FULL            = 360 * UNIT;
  localparam int FOLD            = 300 * UNIT;
  localparam int TEN             = 10 * UNIT;

  // Drive constants.
  localparam int SPEED_LIMIT = 400;
  localparam int SPEED_SCALE = 10 * SPEED_LIMIT;
  localparam int BASE_SPEED  = 100 * 10 * UNIT;
  localparam int TRIM_LEFT   = 374;
  localparam int TRIM_RIGHT  = 353;
  localparam int DIV_SHIFT   = 8 + ANGLE_FRAC_BITS;
  localparam int RECIP10     = 6554;
  localparam int RECIP_SHIFT = 16;
  localparam int PULSE_MID   = 1500;

  // Field and internal widths.
  localparam int HEAD_W     = 13;
  localparam int STEP_W     = 8;
  localparam int SPAN_W     = 13;
  localparam int ERR_W      = 14;
  localparam int WIDE_W     = ERR_W + 1;
  localparam int INT_W      = 9;
  localparam int BIAS_W     = 16;
  localparam int PULSE_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MUL_A_W    = 22;
  localparam int MUL_B_W    = 15;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 22;
  localparam int SHIFTED_W  = PROD_W - DIV_SHIFT;
  localparam int SPV_W      = 14;

  localparam logic signed [WIDE_W-1:0]    FULL_X    = WIDE_W'(FULL);
  localparam logic signed [WIDE_W-1:0]    FOLD_X    = WIDE_W'(FOLD);
  localparam logic signed [WIDE_W-1:0]    TEN_X     = WIDE_W'(TEN);
  localparam logic signed [ACC_W-1:0]     BASE_X    = ACC_W'(BASE_SPEED);
  localparam logic signed [SHIFTED_W-1:0] SCALE_X   = SHIFTED_W'(SPEED_SCALE);
  localparam logic [PULSE_W-1:0]          PULSE_MIN = PULSE_W'(PULSE_MID - SPEED_LIMIT);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_PRESET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_SPAN  = 3'd4;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_SWEEP  = 4'd1;
  localparam logic [OP_W-1:0] OP_GLITCH = 4'd2;
  localparam logic [OP_W-1:0] OP_WRAP   = 4'd3;
  localparam logic [OP_W-1:0] OP_INTEG  = 4'd4;
  localparam logic [OP_W-1:0] OP_MI     = 4'd5;
  localparam logic [OP_W-1:0] OP_MD     = 4'd6;
  localparam logic [OP_W-1:0] OP_SUM    = 4'd7;
  localparam logic [OP_W-1:0] OP_ML     = 4'd8;
  localparam logic [OP_W-1:0] OP_MR     = 4'd9;
  localparam logic [OP_W-1:0] OP_QL     = 4'd10;
  localparam logic [OP_W-1:0] OP_QR     = 4'd11;
  localparam logic [OP_W-1:0] OP_FIN    = 4'd12;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            load_out;
  } cmd_t;

endpackage

### rtl/hpd_ctrl.sv
module hpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output hpd_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SWEEP  = 4'd1;
  localparam logic [3:0] ST_GLITCH = 4'd2;
  localparam logic [3:0] ST_WRAP   = 4'd3;
  localparam logic [3:0] ST_INTEG  = 4'd4;
  localparam logic [3:0] ST_MI     = 4'd5;
  localparam logic [3:0] ST_MD     = 4'd6;
  localparam logic [3:0] ST_SUM    = 4'd7;
  localparam logic [3:0] ST_ML     = 4'd8;
  localparam logic [3:0] ST_MR     = 4'd9;
  localparam logic [3:0] ST_QL     = 4'd10;
  localparam logic [3:0] ST_QR     = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.op        = hpd_pkg::OP_NONE;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.op    = hpd_pkg::OP_SWEEP;
        state_nxt = ST_GLITCH;
      end
      ST_GLITCH: begin
        cmd.op    = hpd_pkg::OP_GLITCH;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.op    = hpd_pkg::OP_WRAP;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.op    = hpd_pkg::OP_INTEG;
        state_nxt = ST_MI;
      end
      ST_MI: begin
        cmd.op    = hpd_pkg::OP_MI;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        cmd.op    = hpd_pkg::OP_MD;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = hpd_pkg::OP_SUM;
        state_nxt = ST_ML;
      end
      ST_ML: begin
        cmd.op    = hpd_pkg::OP_ML;
        state_nxt = ST_MR;
      end
      ST_MR: begin
        cmd.op    = hpd_pkg::OP_MR;
        state_nxt = ST_QL;
      end
      ST_QL: begin
        cmd.op    = hpd_pkg::OP_QL;
        state_nxt = ST_QR;
      end
      ST_QR: begin
        cmd.op    = hpd_pkg::OP_QR;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = hpd_pkg::OP_FIN;
        // Hold the finished beat until the output register is free.
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/hpd_dp.sv
module hpd_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  hpd_pkg::cmd_t                           cmd,
  input  logic                                    cfg_we,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic [hpd_pkg::HEAD_W-1:0]              in_heading,
  input  logic                                    in_start_req,
  output logic [hpd_pkg::PULSE_W-1:0]             out_left_pulse,
  output logic [hpd_pkg::PULSE_W-1:0]             out_right_pulse,
  output logic signed [hpd_pkg::ERR_W-1:0]        out_heading_error
);

  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KP_FINE   = 15'sd150;
  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KP_MID    = 15'sd70;
  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KD_MID    = 15'sd30;
  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KP_COARSE = 15'sd50;
  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KI_COARSE = 15'sd10;
  localparam logic signed [hpd_pkg::MUL_B_W-1:0] KD_COARSE = 15'sd10;

  // Folds an error back into the +-300 degree window in four compare steps.
  function automatic logic signed [hpd_pkg::ERR_W-1:0] wrap_error(
    input logic signed [hpd_pkg::WIDE_W-1:0] e
  );
    logic signed [hpd_pkg::WIDE_W-1:0] w;
    w = e;
    if (w < -hpd_pkg::FULL_X) w = w + hpd_pkg::FULL_X;
    if (w > hpd_pkg::FULL_X)  w = w - hpd_pkg::FULL_X;
    if (w > hpd_pkg::FOLD_X)  w = w - hpd_pkg::FULL_X;
    if (w < -hpd_pkg::FOLD_X) w = w + hpd_pkg::FULL_X;
    return w[hpd_pkg::ERR_W-1:0];
  endfunction

  // Floors a trimmed speed product down to tenths of a speed unit, saturates it
  // and offsets it to a non-negative value ready for the divide by ten.
  function automatic logic [hpd_pkg::SPV_W-1:0] clamp_off(
    input logic signed [hpd_pkg::PROD_W-1:0] p
  );
    logic signed [hpd_pkg::SHIFTED_W-1:0] x;
    x = p[hpd_pkg::PROD_W-1:hpd_pkg::DIV_SHIFT];
    if (x > hpd_pkg::SCALE_X) begin
      x = hpd_pkg::SCALE_X;
    end else if (x < -hpd_pkg::SCALE_X) begin
      x = -hpd_pkg::SCALE_X;
    end
    x = x + hpd_pkg::SCALE_X;
    return x[hpd_pkg::SPV_W-1:0];
  endfunction

  function automatic logic [hpd_pkg::HEAD_W:0] abs_diff(
    input logic [hpd_pkg::HEAD_W-1:0] a,
    input logic [hpd_pkg::HEAD_W-1:0] b
  );
    logic signed [hpd_pkg::HEAD_W:0] d;
    d = signed'({1'b0, a}) - signed'({1'b0, b});
    if (d < 0) d = -d;
    return d;
  endfunction

  // Configuration registers.
  logic                               reverse_r, reverse_nxt;
  logic                               use_preset_r, use_preset_nxt;
  logic [hpd_pkg::HEAD_W-1:0]         preset_r, preset_nxt;
  logic signed [hpd_pkg::STEP_W-1:0]  bias_step_r, bias_step_nxt;
  logic [hpd_pkg::SPAN_W-1:0]         bias_span_r, bias_span_nxt;

  // Controller state carried from beat to beat.
  logic [hpd_pkg::HEAD_W-1:0]         target_r, target_nxt;
  logic [hpd_pkg::HEAD_W-1:0]         last_r, last_nxt;
  logic signed [hpd_pkg::INT_W-1:0]   integ_r, integ_nxt;
  logic signed [hpd_pkg::ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [hpd_pkg::BIAS_W-1:0]  bias_r, bias_nxt;

  // Working registers of one beat.
  logic [hpd_pkg::HEAD_W-1:0]         heading_r, heading_nxt;
  logic signed [hpd_pkg::WIDE_W-1:0]  err_raw_r, err_raw_nxt;
  logic signed [hpd_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic signed [hpd_pkg::WIDE_W-1:0]  diff_r, diff_nxt;
  logic signed [hpd_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [hpd_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [hpd_pkg::SPV_W-1:0]          vl_r, vl_nxt;
  logic [hpd_pkg::SPV_W-1:0]          vr_r, vr_nxt;
  logic [hpd_pkg::PULSE_W-1:0]        left_r, left_nxt;
  logic [hpd_pkg::PULSE_W-1:0]        out_left_r, out_left_nxt;
  logic [hpd_pkg::PULSE_W-1:0]        out_right_r, out_right_nxt;
  logic signed [hpd_pkg::ERR_W-1:0]   out_err_r, out_err_nxt;

  // Combinational helpers.
  logic signed [hpd_pkg::BIAS_W:0]    bias_abs;
  logic                               sweep_stop;
  logic signed [hpd_pkg::WIDE_W-1:0]  sweep_sum;
  logic [hpd_pkg::HEAD_W-1:0]         used;
  logic signed [hpd_pkg::WIDE_W-1:0]  integ_sum;
  logic signed [hpd_pkg::ACC_W-1:0]   base_sel;
  logic signed [hpd_pkg::ACC_W-1:0]   prod_lo;
  logic [hpd_pkg::PULSE_W-1:0]        quot;
  logic signed [hpd_pkg::MUL_B_W-1:0] kp, ki, kd;
  logic signed [hpd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [hpd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [hpd_pkg::PROD_W-1:0]  mul_p;

  assign bias_abs   = (bias_r < 0) ? -(hpd_pkg::BIAS_W+1)'(bias_r)
                                   : (hpd_pkg::BIAS_W+1)'(bias_r);
  assign sweep_stop = $unsigned(bias_abs) > (hpd_pkg::BIAS_W+1)'(bias_span_r);
  assign sweep_sum  = hpd_pkg::WIDE_W'(signed'({1'b0, target_r}))
                    + hpd_pkg::WIDE_W'(bias_step_r);
  assign used       = (abs_diff(last_r, heading_r) > hpd_pkg::TEN &&
                       abs_diff(last_r, target_r) < hpd_pkg::TEN) ? last_r : heading_r;
  assign integ_sum  = hpd_pkg::WIDE_W'(integ_r) + hpd_pkg::WIDE_W'(err_r);
  assign base_sel   = reverse_r ? -hpd_pkg::BASE_X : hpd_pkg::BASE_X;
  assign prod_lo    = signed'(prod_r[hpd_pkg::ACC_W-1:0]);
  assign quot       = prod_r[hpd_pkg::RECIP_SHIFT+hpd_pkg::PULSE_W-1:hpd_pkg::RECIP_SHIFT];

  // Gain schedule on the signed error.
  always_comb begin
    if (err_r < hpd_pkg::UNIT) begin
      kp = KP_FINE;
      ki = '0;
      kd = '0;
    end else if (err_r < 3 * hpd_pkg::UNIT) begin
      kp = KP_MID;
      ki = '0;
      kd = KD_MID;
    end else begin
      kp = KP_COARSE;
      ki = KI_COARSE;
      kd = KD_COARSE;
    end
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      hpd_pkg::OP_INTEG: begin
        mul_a = hpd_pkg::MUL_A_W'(err_r);
        mul_b = kp;
      end
      hpd_pkg::OP_MI: begin
        mul_a = hpd_pkg::MUL_A_W'(integ_r);
        mul_b = ki;
      end
      hpd_pkg::OP_MD: begin
        mul_a = hpd_pkg::MUL_A_W'(diff_r);
        mul_b = kd;
      end
      hpd_pkg::OP_ML: begin
        mul_a = hpd_pkg::MUL_A_W'(base_sel + acc_r);
        mul_b = hpd_pkg::MUL_B_W'(hpd_pkg::TRIM_LEFT);
      end
      hpd_pkg::OP_MR: begin
        mul_a = hpd_pkg::MUL_A_W'(acc_r - base_sel);
        mul_b = hpd_pkg::MUL_B_W'(hpd_pkg::TRIM_RIGHT);
      end
      hpd_pkg::OP_QL: begin
        mul_a = hpd_pkg::MUL_A_W'(vl_r);
        mul_b = hpd_pkg::MUL_B_W'(hpd_pkg::RECIP10);
      end
      hpd_pkg::OP_QR: begin
        mul_a = hpd_pkg::MUL_A_W'(vr_r);
        mul_b = hpd_pkg::MUL_B_W'(hpd_pkg::RECIP10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = hpd_pkg::PROD_W'(mul_a) * hpd_pkg::PROD_W'(mul_b);

  always_comb begin
    reverse_nxt    = reverse_r;
    use_preset_nxt = use_preset_r;
    preset_nxt     = preset_r;
    bias_step_nxt  = bias_step_r;
    bias_span_nxt  = bias_span_r;
    target_nxt     = target_r;
    last_nxt       = last_r;
    integ_nxt      = integ_r;
    prev_nxt       = prev_r;
    bias_nxt       = bias_r;
    heading_nxt    = heading_r;
    err_raw_nxt    = err_raw_r;
    err_nxt        = err_r;
    diff_nxt       = diff_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    vl_nxt         = vl_r;
    vr_nxt         = vr_r;
    left_nxt       = left_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_err_nxt    = out_err_r;

    if (cfg_we) begin
      unique case (cfg_index)
        hpd_pkg::REG_REVERSE:    reverse_nxt    = cfg_data[0];
        hpd_pkg::REG_USE_PRESET: use_preset_nxt = cfg_data[0];
        hpd_pkg::REG_PRESET:     preset_nxt     = cfg_data[hpd_pkg::HEAD_W-1:0];
        hpd_pkg::REG_BIAS_STEP:  bias_step_nxt  = signed'(cfg_data[hpd_pkg::STEP_W-1:0]);
        hpd_pkg::REG_BIAS_SPAN:  bias_span_nxt  = cfg_data[hpd_pkg::SPAN_W-1:0];
        default: begin
        end
      endcase
    end

    if (cmd.accept) begin
      heading_nxt = in_heading;
      if (in_start_req) begin
        target_nxt = use_preset_r ? preset_r : in_heading;
        last_nxt   = in_heading;
        integ_nxt  = '0;
        prev_nxt   = '0;
        bias_nxt   = '0;
      end
    end

    unique case (cmd.op)
      hpd_pkg::OP_SWEEP: begin
        if (!sweep_stop) begin
          bias_nxt = bias_r + hpd_pkg::BIAS_W'(bias_step_r);
          if (sweep_sum > hpd_pkg::FULL_X) begin
            target_nxt = hpd_pkg::HEAD_W'(sweep_sum - hpd_pkg::FULL_X);
          end else if (sweep_sum < 0) begin
            target_nxt = hpd_pkg::HEAD_W'(sweep_sum + hpd_pkg::FULL_X);
          end else begin
            target_nxt = hpd_pkg::HEAD_W'(sweep_sum);
          end
        end
      end
      hpd_pkg::OP_GLITCH: begin
        err_raw_nxt = hpd_pkg::WIDE_W'(signed'({1'b0, used}))
                    - hpd_pkg::WIDE_W'(signed'({1'b0, target_r}));
        last_nxt    = heading_r;
      end
      hpd_pkg::OP_WRAP: begin
        err_nxt = wrap_error(err_raw_r);
      end
      hpd_pkg::OP_INTEG: begin
        diff_nxt = hpd_pkg::WIDE_W'(prev_r) - hpd_pkg::WIDE_W'(err_r);
        if (!(integ_sum > hpd_pkg::TEN_X || integ_sum < -hpd_pkg::TEN_X)) begin
          integ_nxt = integ_sum[hpd_pkg::INT_W-1:0];
        end
        prev_nxt = err_r;
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_MI: begin
        acc_nxt  = prod_lo;
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_MD: begin
        acc_nxt  = acc_r + prod_lo;
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_SUM: begin
        acc_nxt = acc_r + prod_lo;
      end
      hpd_pkg::OP_ML: begin
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_MR: begin
        vl_nxt   = clamp_off(prod_r);
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_QL: begin
        vr_nxt   = clamp_off(prod_r);
        prod_nxt = mul_p;
      end
      hpd_pkg::OP_QR: begin
        left_nxt = hpd_pkg::PULSE_MIN + quot;
        prod_nxt = mul_p;
      end
      default: begin
      end
    endcase

    if (cmd.load_out) begin
      out_left_nxt  = left_r;
      out_right_nxt = hpd_pkg::PULSE_MIN + quot;
      out_err_nxt   = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r    <= 1'b0;
      use_preset_r <= 1'b0;
      preset_r     <= '0;
      bias_step_r  <= '0;
      bias_span_r  <= '0;
      target_r     <= '0;
      last_r       <= '0;
      integ_r      <= '0;
      prev_r       <= '0;
      bias_r       <= '0;
    end else begin
      reverse_r    <= reverse_nxt;
      use_preset_r <= use_preset_nxt;
      preset_r     <= preset_nxt;
      bias_step_r  <= bias_step_nxt;
      bias_span_r  <= bias_span_nxt;
      target_r     <= target_nxt;
      last_r       <= last_nxt;
      integ_r      <= integ_nxt;
      prev_r       <= prev_nxt;
      bias_r       <= bias_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heading_r   <= heading_nxt;
    err_raw_r   <= err_raw_nxt;
    err_r       <= err_nxt;
    diff_r      <= diff_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    vl_r        <= vl_nxt;
    vr_r        <= vr_nxt;
    left_r      <= left_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_left_pulse    = out_left_r;
  assign out_right_pulse   = out_right_r;
  assign out_heading_error = out_err_r;

endmodule

### rtl/heading_pid_drive_top.sv
// A heading sample is taken only once the one before it is through; the shared multiplier makes
// seven passes per sample (three gain products, two wheel trims, two divides by ten).
// A result waiting on out_stall holds only the last step; the next sample is taken meanwhile.
// Reset (rst_n, synchronous, active low) clears the configuration registers, the target,
// last heading, integral, previous error and bias total, and empties the output register.
module heading_pid_drive_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hpd_pkg::HEAD_W-1:0]          in_heading,
  input  logic                                in_start_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hpd_pkg::PULSE_W-1:0]         out_left_pulse,
  output logic [hpd_pkg::PULSE_W-1:0]         out_right_pulse,
  output logic signed [hpd_pkg::ERR_W-1:0]    out_heading_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // The controller steps one sample through the datapath: target sweep,
  // glitch rejection, error wrap, integral update, then the multiplier passes.
  hpd_pkg::cmd_t cmd;
  logic          cfg_we;

  // Registers are simple flops, so a configuration beat is always taken.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  hpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hpd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_heading        (in_heading),
    .in_start_req      (in_start_req),
    .out_left_pulse    (out_left_pulse),
    .out_right_pulse   (out_right_pulse),
    .out_heading_error (out_heading_error)
  );

  // Once a beat is taken, the input side stays stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a sample was still in progress");

  // The output register is only reloaded when its previous beat is gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // A wrapped error always lies inside the +-300 degree window.
  a_error_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_error <= hpd_pkg::FOLD &&
                   out_heading_error >= -hpd_pkg::FOLD))
    else $error("heading error outside the wrap window");

  // Saturated speeds keep both pulse widths inside the servo range.
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_pulse >= hpd_pkg::PULSE_MIN &&
                   out_left_pulse <= hpd_pkg::PULSE_MID + hpd_pkg::SPEED_LIMIT &&
                   out_right_pulse >= hpd_pkg::PULSE_MIN &&
                   out_right_pulse <= hpd_pkg::PULSE_MID + hpd_pkg::SPEED_LIMIT))
    else $error("servo pulse width outside the saturation range");

endmodule
